// ----- sv/lc_pkg.sv -----
`timescale 1ns / 1ps

package lc_pkg;

  localparam int MAX_TAPS_DEF     = 64;
  localparam int SAMPLE_WIDTH_DEF = 16;
  localparam int SAMPLE_WIDTH_MAX = 24;
  localparam int VALUE_WIDTH      = 16;
  localparam int TAP_INDEX_WIDTH  = 6;
  localparam int RESULT_WIDTH     = 40;
  localparam int TAPS_CFG_WIDTH   = 7;
  localparam int IN_TDATA_WIDTH   = 24;
  localparam int OUT_TDATA_WIDTH  = 40;

  localparam logic [TAPS_CFG_WIDTH-1:0] TAPS_RESET = 7'd16;

  localparam logic MODE_TAP    = 1'b0;
  localparam logic MODE_SAMPLE = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN,
    ST_EMIT
  } lc_state_e;

  typedef struct packed {
    logic kern_we;
    logic push_sample;
    logic push_zero;
    logic issue;
    logic first_tap;
    logic last_tap;
    logic load_out;
    logic final_flag;
    logic clear_line;
  } lc_cmd_t;

  typedef struct packed {
    logic sum_done;
    logic out_free;
  } lc_status_t;

endpackage

// ----- sv/lc_datapath.sv -----
`timescale 1ns / 1ps

module lc_datapath #(
  parameter int MAX_TAPS     = lc_pkg::MAX_TAPS_DEF,
  parameter int SAMPLE_WIDTH = lc_pkg::SAMPLE_WIDTH_DEF,
  parameter int AW           = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  lc_pkg::lc_cmd_t                       cmd_i,
  input  logic [AW-1:0]                         tap_idx_i,
  input  logic [lc_pkg::VALUE_WIDTH-1:0]        value_i,
  input  logic [lc_pkg::TAP_INDEX_WIDTH-1:0]    tap_index_i,
  output lc_pkg::lc_status_t                    status_o,
  output logic [lc_pkg::OUT_TDATA_WIDTH-1:0]    m_axis_tdata_o,
  output logic                                  m_axis_tvalid_o,
  output logic                                  m_axis_tlast_o,
  input  logic                                  m_axis_tready_i
);
  import lc_pkg::*;

  localparam int PW = 2 * SAMPLE_WIDTH;

  logic [SAMPLE_WIDTH_MAX-1:0] val_ext;
  logic [SAMPLE_WIDTH-1:0]     sample;
  logic                        idx_ok;
  logic [AW-1:0]               kaddr;
  logic [AW-1:0]               wp_inc;
  logic [AW-1:0]               rp_dec;

  logic [SAMPLE_WIDTH-1:0] kern_mem [MAX_TAPS];
  logic [SAMPLE_WIDTH-1:0] line_mem [MAX_TAPS];
  logic [MAX_TAPS-1:0]     line_vld_q;

  logic [AW-1:0] wp_q, rp_q;

  logic                    s1_vld_q, s1_first_q, s1_last_q;
  logic [SAMPLE_WIDTH-1:0] kern_rd_q, line_rd_q;
  logic                    line_ok_q;

  logic                    s2_vld_q, s2_first_q, s2_last_q;
  logic signed [PW-1:0]    prod_q;

  logic signed [RESULT_WIDTH-1:0] acc_q;
  logic                           done_q;

  logic                           out_valid_q;
  logic [RESULT_WIDTH-1:0]        out_data_q;
  logic                           out_last_q;

  assign val_ext = SAMPLE_WIDTH_MAX'(value_i);
  assign sample  = val_ext[SAMPLE_WIDTH-1:0];
  assign idx_ok  = 32'(tap_index_i) < MAX_TAPS;
  assign kaddr   = AW'(tap_index_i);
  assign wp_inc  = (wp_q == AW'(MAX_TAPS - 1)) ? '0 : wp_q + 1'b1;
  assign rp_dec  = (rp_q == '0) ? AW'(MAX_TAPS - 1) : rp_q - 1'b1;

  always_ff @(posedge clk_i) begin
    if (cmd_i.kern_we && idx_ok) begin
      kern_mem[kaddr] <= sample;
    end
    kern_rd_q <= kern_mem[tap_idx_i];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.push_sample) begin
      line_mem[wp_q] <= sample;
    end
    line_rd_q <= line_mem[rp_q];
    line_ok_q <= line_vld_q[rp_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_vld_q <= '0;
    end else if (cmd_i.clear_line) begin
      line_vld_q <= '0;
    end else if (cmd_i.push_sample) begin
      line_vld_q[wp_q] <= 1'b1;
    end else if (cmd_i.push_zero) begin
      line_vld_q[wp_q] <= 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0;
      rp_q <= '0;
    end else if (cmd_i.push_sample || cmd_i.push_zero) begin
      wp_q <= wp_inc;
      rp_q <= wp_q;
    end else if (cmd_i.issue) begin
      rp_q <= rp_dec;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q   <= 1'b0;
      s1_first_q <= 1'b0;
      s1_last_q  <= 1'b0;
      s2_vld_q   <= 1'b0;
      s2_first_q <= 1'b0;
      s2_last_q  <= 1'b0;
      done_q     <= 1'b0;
    end else begin
      s1_vld_q   <= cmd_i.issue;
      s1_first_q <= cmd_i.first_tap;
      s1_last_q  <= cmd_i.last_tap;
      s2_vld_q   <= s1_vld_q;
      s2_first_q <= s1_first_q;
      s2_last_q  <= s1_last_q;
      done_q     <= s2_vld_q && s2_last_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_vld_q) begin
      prod_q <= $signed(kern_rd_q) * $signed(line_ok_q ? line_rd_q : '0);
    end
    if (s2_vld_q) begin
      acc_q <= (s2_first_q ? '0 : acc_q) + RESULT_WIDTH'(prod_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_data_q <= acc_q;
      out_last_q <= cmd_i.final_flag;
    end
  end

  assign status_o.sum_done = done_q;
  assign status_o.out_free = !out_valid_q || m_axis_tready_i;

  assign m_axis_tdata_o  = OUT_TDATA_WIDTH'(out_data_q);
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tlast_o  = out_last_q;

  a_load_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load_out |-> (!out_valid_q || m_axis_tready_i))
    else $error("result loaded over an untaken transfer");

  a_done_follows_last_tap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(cmd_i.issue && cmd_i.last_tap, 3))
    else $error("sum completed without a final tap issue");

endmodule

// ----- sv/lc_controller.sv -----
`timescale 1ns / 1ps

module lc_controller #(
  parameter int MAX_TAPS = lc_pkg::MAX_TAPS_DEF,
  parameter int AW       = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [lc_pkg::TAPS_CFG_WIDTH-1:0]   cfg_wdata_i,
  input  logic                                s_axis_tvalid_i,
  input  logic                                s_axis_tuser_i,
  input  logic                                s_axis_tlast_i,
  output logic                                s_axis_tready_o,
  output lc_pkg::lc_cmd_t                     cmd_o,
  output logic [AW-1:0]                       tap_idx_o,
  input  lc_pkg::lc_status_t                  status_i
);
  import lc_pkg::*;

  lc_state_e state_q, state_d;
  logic [TAPS_CFG_WIDTH-1:0] taps_q;
  logic [TAPS_CFG_WIDTH-1:0] active;
  logic [AW-1:0] j_q, j_d, k_q, k_d, last_idx_q, last_idx_d;
  logic          last_q, last_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      taps_q <= TAPS_RESET;
    end else if (cfg_we_i) begin
      taps_q <= cfg_wdata_i;
    end
  end

  assign active = (taps_q == '0) ? TAPS_CFG_WIDTH'(1) :
                  (taps_q > TAPS_CFG_WIDTH'(MAX_TAPS)) ? TAPS_CFG_WIDTH'(MAX_TAPS) : taps_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      j_q        <= '0;
      k_q        <= '0;
      last_idx_q <= '0;
      last_q     <= 1'b0;
    end else begin
      state_q    <= state_d;
      j_q        <= j_d;
      k_q        <= k_d;
      last_idx_q <= last_idx_d;
      last_q     <= last_d;
    end
  end

  always_comb begin
    state_d         = state_q;
    j_d             = j_q;
    k_d             = k_q;
    last_idx_d      = last_idx_q;
    last_d          = last_q;
    cmd_o           = '0;
    s_axis_tready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        s_axis_tready_o = 1'b1;
        if (s_axis_tvalid_i) begin
          if (s_axis_tuser_i == MODE_SAMPLE) begin
            cmd_o.push_sample = 1'b1;
            j_d        = '0;
            k_d        = '0;
            last_d     = s_axis_tlast_i;
            last_idx_d = AW'(active - TAPS_CFG_WIDTH'(1));
            state_d    = ST_RUN;
          end else begin
            cmd_o.kern_we = 1'b1;
          end
        end
      end
      ST_RUN: begin
        cmd_o.issue     = 1'b1;
        cmd_o.first_tap = (j_q == '0);
        cmd_o.last_tap  = (j_q == last_idx_q);
        if (j_q == last_idx_q) begin
          state_d = ST_DRAIN;
        end else begin
          j_d = j_q + 1'b1;
        end
      end
      ST_DRAIN: begin
        if (status_i.sum_done) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (status_i.out_free) begin
          cmd_o.load_out   = 1'b1;
          cmd_o.final_flag = last_q && (k_q == last_idx_q);
          if (last_q && (k_q != last_idx_q)) begin
            cmd_o.push_zero = 1'b1;
            k_d     = k_q + 1'b1;
            j_d     = '0;
            state_d = ST_RUN;
          end else begin
            cmd_o.clear_line = last_q;
            state_d          = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign tap_idx_o = j_q;

  a_tap_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RUN) |-> (j_q <= last_idx_q))
    else $error("tap counter beyond taps in use");

  a_flush_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE) |-> (k_q <= last_idx_q))
    else $error("flush counter beyond taps in use");

  a_sample_starts_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o && s_axis_tuser_i == MODE_SAMPLE)
      |=> (state_q == ST_RUN))
    else $error("sample transfer did not start a sum");

endmodule

// ----- sv/linear_convolution.sv -----
`timescale 1ns / 1ps
// One shared MAC walks the taps of each sample; tap loads are written while the
// controller stays idle. A new item is taken once the previous item's last result
// sits in the output register.
// Reset: taps_in_use returns to 16 and the delay line clears; kernel taps are
// undefined until written.

module linear_convolution #(
  parameter int MAX_TAPS     = lc_pkg::MAX_TAPS_DEF,
  parameter int SAMPLE_WIDTH = lc_pkg::SAMPLE_WIDTH_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [lc_pkg::TAPS_CFG_WIDTH-1:0]   cfg_wdata_i,
  input  logic                                s_axis_tvalid_i,
  output logic                                s_axis_tready_o,
  // [15:0] value, [21:16] tap_index, [23:22] zero
  input  logic [lc_pkg::IN_TDATA_WIDTH-1:0]   s_axis_tdata_i,
  // [0] mode
  input  logic                                s_axis_tuser_i,
  input  logic                                s_axis_tlast_i,
  output logic                                m_axis_tvalid_o,
  input  logic                                m_axis_tready_i,
  // [39:0] result
  output logic [lc_pkg::OUT_TDATA_WIDTH-1:0]  m_axis_tdata_o,
  output logic                                m_axis_tlast_o
);
  import lc_pkg::*;

  localparam int AW = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;

  lc_cmd_t    cmd;
  lc_status_t status;
  logic [AW-1:0] tap_idx;

  lc_controller #(
    .MAX_TAPS (MAX_TAPS),
    .AW       (AW)
  ) u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .s_axis_tlast_i  (s_axis_tlast_i),
    .s_axis_tready_o (s_axis_tready_o),
    .cmd_o           (cmd),
    .tap_idx_o       (tap_idx),
    .status_i        (status)
  );

  lc_datapath #(
    .MAX_TAPS     (MAX_TAPS),
    .SAMPLE_WIDTH (SAMPLE_WIDTH),
    .AW           (AW)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .tap_idx_i       (tap_idx),
    .value_i         (s_axis_tdata_i[VALUE_WIDTH-1:0]),
    .tap_index_i     (s_axis_tdata_i[VALUE_WIDTH+TAP_INDEX_WIDTH-1:VALUE_WIDTH]),
    .status_o        (status),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tlast_o  (m_axis_tlast_o),
    .m_axis_tready_i (m_axis_tready_i)
  );

endmodule

// ----- bench/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
  import lc_pkg::*;

  localparam int NUM_TAPS     = MAX_TAPS_DEF;
  localparam int SETTLE_CYC   = NUM_TAPS + 16;
  localparam int STALL_LIMIT  = 20000;
  localparam int SHOW_LIMIT   = 10;

  typedef struct packed {
    logic [RESULT_WIDTH-1:0] sum;
    logic                    fin;
  } conv_out_t;

  logic                        clk_i = 1'b0;
  logic                        rst_ni = 1'b0;
  logic                        cfg_we_i = 1'b0;
  logic [TAPS_CFG_WIDTH-1:0]   cfg_wdata_i = '0;
  logic                        s_axis_tvalid_i = 1'b0;
  logic                        s_axis_tready_o;
  logic [IN_TDATA_WIDTH-1:0]   s_axis_tdata_i = '0;
  logic                        s_axis_tuser_i = 1'b0;
  logic                        s_axis_tlast_i = 1'b0;
  logic                        m_axis_tvalid_o;
  logic                        m_axis_tready_i = 1'b0;
  logic [OUT_TDATA_WIDTH-1:0]  m_axis_tdata_o;
  logic                        m_axis_tlast_o;

  logic signed [VALUE_WIDTH-1:0] kernel [NUM_TAPS];
  logic signed [VALUE_WIDTH-1:0] delay_line [NUM_TAPS-1];
  logic [TAPS_CFG_WIDTH-1:0]     taps_cfg;
  conv_out_t                     pending_outputs [$];

  int src_idle_pct = 0;
  int snk_idle_pct = 0;
  int n_taps_loaded = 0;
  int n_samples = 0;
  int n_signals = 0;
  int n_outputs = 0;
  int n_mismatch = 0;
  int quiet_cycles = 0;

  linear_convolution uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .s_axis_tlast_i  (s_axis_tlast_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  always #5 clk_i = ~clk_i;

  function automatic int active_taps();
    if (taps_cfg == 0) return 1;
    if (taps_cfg > NUM_TAPS) return NUM_TAPS;
    return int'(taps_cfg);
  endfunction

  function automatic logic [RESULT_WIDTH-1:0] shift_and_sum(logic signed [VALUE_WIDTH-1:0] x,
                                                           int n);
    longint acc;
    acc = longint'(kernel[0]) * longint'(x);
    for (int j = 1; j < n; j++) acc += longint'(kernel[j]) * longint'(delay_line[j-1]);
    for (int j = NUM_TAPS - 2; j > 0; j--) delay_line[j] = delay_line[j-1];
    delay_line[0] = x;
    return acc[RESULT_WIDTH-1:0];
  endfunction

  function automatic void predict_outputs(logic mode, logic [VALUE_WIDTH-1:0] value,
                                          logic [TAP_INDEX_WIDTH-1:0] index, logic last);
    int n;
    conv_out_t o;
    if (mode == MODE_TAP) begin
      kernel[index] = value;
      n_taps_loaded++;
      return;
    end
    n = active_taps();
    n_samples++;
    o.sum = shift_and_sum(value, n);
    o.fin = last && (n == 1);
    pending_outputs.push_back(o);
    if (last) begin
      n_signals++;
      for (int k = 1; k < n; k++) begin
        o.sum = shift_and_sum('0, n);
        o.fin = (k == n - 1);
        pending_outputs.push_back(o);
      end
      for (int j = 0; j < NUM_TAPS - 1; j++) delay_line[j] = '0;
    end
  endfunction

  function automatic logic [VALUE_WIDTH-1:0] pick_value();
    case ($urandom_range(9))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'hFFFF;
      3: return 16'h0000;
      default: return VALUE_WIDTH'($urandom);
    endcase
  endfunction

  task automatic send_item(input logic mode, input logic [VALUE_WIDTH-1:0] value,
                           input logic [TAP_INDEX_WIDTH-1:0] index, input logic last);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {2'b00, index, value};
    s_axis_tuser_i  <= mode;
    s_axis_tlast_i  <= last;
    do @(posedge clk_i); while (!s_axis_tready_o);
    predict_outputs(mode, value, index, last);
  endtask

  task automatic send_sample(input logic [VALUE_WIDTH-1:0] value, input logic last);
    send_item(MODE_SAMPLE, value, TAP_INDEX_WIDTH'($urandom_range(63)), last);
  endtask

  task automatic drain();
    s_axis_tvalid_i <= 1'b0;
    while (pending_outputs.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYC) @(posedge clk_i);
  endtask

  task automatic set_taps(input logic [TAPS_CFG_WIDTH-1:0] v);
    drain();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    taps_cfg = v;
  endtask

  task automatic test_single_tap();
    set_taps(7'd1);
    send_item(MODE_TAP, 16'h8000, 6'd0, 1'b0);
    send_sample(16'h7FFF, 1'b0);
    send_sample(16'h8000, 1'b1);
    set_taps(7'd0);
    send_sample(16'h8000, 1'b1);
    // last flag on a tap load must be ignored
    send_item(MODE_TAP, 16'h7FFF, 6'd0, 1'b1);
    send_sample(16'hFFFF, 1'b0);
    send_sample(16'h7FFF, 1'b1);
  endtask

  task automatic test_short_kernel();
    set_taps(7'd3);
    send_item(MODE_TAP, 16'h8000, 6'd1, 1'b0);
    send_item(MODE_TAP, 16'h7FFF, 6'd2, 1'b0);
    send_sample(16'h8000, 1'b0);
    send_sample(16'h8000, 1'b0);
    send_sample(16'h7FFF, 1'b1);
    send_sample(16'h0001, 1'b1);
  endtask

  task automatic test_full_kernel();
    send_item(MODE_TAP, 16'h7FFF, 6'd0, 1'b0);
    for (int i = 1; i < NUM_TAPS - 1; i++) send_item(MODE_TAP, pick_value(), 6'(i), 1'b0);
    send_item(MODE_TAP, 16'h8000, 6'd63, 1'b0);
    set_taps(7'd127);
    send_sample(16'h8000, 1'b0);
    send_sample(16'h8000, 1'b0);
    send_sample(16'h7FFF, 1'b1);
    set_taps(7'd64);
    send_sample(16'h8000, 1'b1);
  endtask

  task automatic random_traffic(input logic [TAPS_CFG_WIDTH-1:0] taps, input int n_items);
    int sent;
    int len;
    set_taps(taps);
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(99) < 15) begin
        send_item(MODE_TAP, pick_value(), TAP_INDEX_WIDTH'($urandom_range(63)),
                  1'($urandom_range(1)));
        sent++;
      end else begin
        len = $urandom_range(1, 8);
        for (int i = 0; i < len; i++) send_sample(pick_value(), i == len - 1);
        sent += len;
      end
    end
  endtask

  task automatic test_sink_stalls();
    src_idle_pct = 10;
    snk_idle_pct = 82;
    random_traffic(7'($urandom_range(2, 12)), 40);
    random_traffic(7'd1, 35);
  endtask

  task automatic test_source_gaps();
    src_idle_pct = 82;
    snk_idle_pct = 10;
    random_traffic(7'd64, 30);
    random_traffic(7'($urandom_range(0, 127)), 40);
  endtask

  task automatic test_back_to_back();
    src_idle_pct = 0;
    snk_idle_pct = 0;
    random_traffic(7'($urandom_range(1, 64)), 40);
    random_traffic(7'($urandom_range(2, 6)), 36);
  endtask

  always @(posedge clk_i) begin
    m_axis_tready_i <= ($urandom_range(99) >= snk_idle_pct);
  end

  always @(posedge clk_i) begin
    conv_out_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      n_outputs++;
      if (pending_outputs.size() == 0) begin
        n_mismatch++;
        if (n_mismatch <= SHOW_LIMIT)
          $display("unexpected output: result %0d final %0b",
                   $signed(m_axis_tdata_o), m_axis_tlast_o);
      end else begin
        want = pending_outputs.pop_front();
        if (m_axis_tdata_o !== want.sum || m_axis_tlast_o !== want.fin) begin
          n_mismatch++;
          if (n_mismatch <= SHOW_LIMIT)
            $display("output %0d: expected result %0d final %0b, got result %0d final %0b",
                     n_outputs, $signed(want.sum), want.fin,
                     $signed(m_axis_tdata_o), m_axis_tlast_o);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("watchdog: no transfer for %0d cycles", STALL_LIMIT);
        $display("status: fail");
        $finish;
      end
    end
  end

  initial begin
    for (int j = 0; j < NUM_TAPS; j++) kernel[j] = '0;
    for (int j = 0; j < NUM_TAPS - 1; j++) delay_line[j] = '0;
    taps_cfg = TAPS_RESET;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_single_tap();
    test_short_kernel();
    test_full_kernel();
    test_sink_stalls();
    test_source_gaps();
    test_back_to_back();
    drain();
    $display("covered %0d tap loads, %0d samples in %0d signals, %0d outputs checked",
             n_taps_loaded, n_samples, n_signals, n_outputs);
    $display("tap counts from 0 to 127 under sink stalls, source gaps and full rate");
    if (n_mismatch == 0) begin
      $display("status: pass");
    end else begin
      $display("%0d mismatches", n_mismatch);
      $display("status: fail");
    end
    $finish;
  end

endmodule
